>>> design/assert_macros.svh
// Assertion macros shared by the affine inverse RTL.
// Uses the clk and rst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, disabled in reset
`define AFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled in reset
`define AFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// property checked in the cycle after reset is applied
`define AFF_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);
`endif

>>> design/aff_pkg.sv
// Shared types and constants of the affine inverse datapath.
// No dependencies.
package aff_pkg;

  localparam int NLANE  = 9;
  localparam int NTRANS = 3;

  // cofactor k = m[i0]*m[i1] - m[i2]*m[i3], row-major 3x3 input
  localparam int COF_IDX [NLANE][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // cofactors that pair with row 0 in the determinant expansion
  localparam int DET_ADJ [NTRANS] = '{0, 3, 6};

  typedef struct packed {
    logic en;
    logic vld;
  } aff_ctl_t;

endpackage

>>> design/aff_if.sv
// Valid/ready channel interfaces for the affine inverse block.
// Standalone; width set by parameter W.
interface aff_in_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic signed [W-1:0] in_r0c0, in_r0c1, in_r0c2;
  logic signed [W-1:0] in_r1c0, in_r1c1, in_r1c2;
  logic signed [W-1:0] in_r2c0, in_r2c1, in_r2c2;
  logic signed [W-1:0] in_tx, in_ty, in_tz;
  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, in_tx, in_ty, in_tz, input ready);
  modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                in_r2c0, in_r2c1, in_r2c2, in_tx, in_ty, in_tz, output ready);
endinterface

interface aff_out_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic signed [W-1:0] out_r0c0, out_r0c1, out_r0c2;
  logic signed [W-1:0] out_r1c0, out_r1c1, out_r1c2;
  logic signed [W-1:0] out_r2c0, out_r2c1, out_r2c2;
  logic signed [W-1:0] out_tx, out_ty, out_tz;
  modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                  out_r1c2, out_r2c0, out_r2c1, out_r2c2, out_tx, out_ty, out_tz,
                  input ready);
  modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1,
                out_r1c2, out_r2c0, out_r2c1, out_r2c2, out_tx, out_ty, out_tz,
                output ready);
endinterface

>>> design/affine_matrix_inverse_unit.sv
// Top level of the affine 3x4 inverse: cofactors, determinant, divider, output.
// Depends on aff_pkg, aff_if, the aff_* stages and assert_macros.svh.
//
// channel   dir  handshake            payload
// in_ch     in   valid/ready          3x3 linear part + translation, Q(W-F).F
// out_ch    out  valid/ready          inverse linear part + translation, saturated
//
// One request enters per cycle while the output register is not stalled.
// The divider has WORD_BITS + 2 stages: an overflow stage, then one quotient bit per stage.
// Reset clears the valid bit of every stage; data registers carry no reset.
// The whole pipeline holds when the output register is full and not taken,
// so nothing is dropped or repeated; an empty output slot lets it advance.
`include "assert_macros.svh"
module affine_matrix_inverse_unit import aff_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  aff_in_if.sink     in_ch,
  aff_out_if.source  out_ch
);
  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;

  logic                adv;
  logic signed [W-1:0] m_in [NLANE];
  logic signed [W-1:0] t_in [NTRANS];

  // cofactor outputs
  logic                cof_vld;
  logic signed [W-1:0] cof_r0 [NTRANS];
  logic signed [W-1:0] cof_t [NTRANS];
  logic signed [2*W:0] cof_adj [NLANE];

  // determinant outputs
  logic                det_vld;
  logic [2*W+2*F:0]    det_num [NLANE];
  logic                det_neg [NLANE];
  logic [3*W+1:0]      det_den;
  logic                det_degen;
  logic signed [W-1:0] det_t [NTRANS];

  // divider outputs
  logic                div_vld;
  logic [W:0]          div_mag [NLANE];
  logic                div_ovf [NLANE];
  logic                div_neg [NLANE];
  logic                div_degen;
  logic signed [W-1:0] div_t [NTRANS];

  logic signed [W-1:0] res_m [NLANE];
  logic signed [W-1:0] res_t [NTRANS];

  // advance every stage unless a finished request waits at the output
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  assign m_in = '{in_ch.in_r0c0, in_ch.in_r0c1, in_ch.in_r0c2,
                  in_ch.in_r1c0, in_ch.in_r1c1, in_ch.in_r1c2,
                  in_ch.in_r2c0, in_ch.in_r2c1, in_ch.in_r2c2};
  assign t_in = '{in_ch.in_tx, in_ch.in_ty, in_ch.in_tz};

  aff_cofactor #(.W(W)) u_cof (
    .clk(clk), .rst_n(rst_n),
    .ctl_i('{en: adv, vld: in_ch.valid}),
    .m_i(m_in), .t_i(t_in),
    .vld_o(cof_vld), .r0_o(cof_r0), .t_o(cof_t), .adj_o(cof_adj)
  );

  aff_det #(.W(W), .F(F)) u_det (
    .clk(clk), .rst_n(rst_n),
    .ctl_i('{en: adv, vld: cof_vld}),
    .r0_i(cof_r0), .t_i(cof_t), .adj_i(cof_adj),
    .vld_o(det_vld), .num_o(det_num), .neg_o(det_neg), .den_o(det_den),
    .degen_o(det_degen), .t_o(det_t)
  );

  aff_div #(.W(W), .F(F)) u_div (
    .clk(clk), .rst_n(rst_n),
    .ctl_i('{en: adv, vld: det_vld}),
    .num_i(det_num), .neg_i(det_neg), .den_i(det_den),
    .degen_i(det_degen), .t_i(det_t),
    .vld_o(div_vld), .mag_o(div_mag), .ovf_o(div_ovf), .neg_o(div_neg),
    .degen_o(div_degen), .t_o(div_t)
  );

  aff_xlate #(.W(W), .F(F)) u_xlate (
    .clk(clk), .rst_n(rst_n),
    .ctl_i('{en: adv, vld: div_vld}),
    .mag_i(div_mag), .ovf_i(div_ovf), .neg_i(div_neg),
    .degen_i(div_degen), .t_i(div_t),
    .vld_o(out_ch.valid), .m_o(res_m), .t_o(res_t)
  );

  assign out_ch.out_r0c0 = res_m[0];
  assign out_ch.out_r0c1 = res_m[1];
  assign out_ch.out_r0c2 = res_m[2];
  assign out_ch.out_r1c0 = res_m[3];
  assign out_ch.out_r1c1 = res_m[4];
  assign out_ch.out_r1c2 = res_m[5];
  assign out_ch.out_r2c0 = res_m[6];
  assign out_ch.out_r2c1 = res_m[7];
  assign out_ch.out_r2c2 = res_m[8];
  assign out_ch.out_tx   = res_t[0];
  assign out_ch.out_ty   = res_t[1];
  assign out_ch.out_tz   = res_t[2];

  `AFF_ASSERT_RST(a_rst_empty, !out_ch.valid, "output valid right after reset")
  `AFF_ASSERT_IMP(a_backpress, out_ch.valid && !out_ch.ready, !in_ch.ready, "input taken while output stalled")

endmodule

>>> design/aff_cofactor.sv
// Cofactor stages: two-term products, then the nine exact cofactors.
// Depends on aff_pkg.
module aff_cofactor import aff_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  aff_ctl_t            ctl_i,
  input  logic signed [W-1:0] m_i [NLANE],
  input  logic signed [W-1:0] t_i [NTRANS],
  output logic                vld_o,
  output logic signed [W-1:0] r0_o [NTRANS],
  output logic signed [W-1:0] t_o [NTRANS],
  output logic signed [2*W:0] adj_o [NLANE]
);
  localparam int CW = 2*W + 1;

  logic signed [2*W-1:0] pa_r [NLANE];
  logic signed [2*W-1:0] pb_r [NLANE];
  logic signed [W-1:0]   r0_a_r [NTRANS];
  logic signed [W-1:0]   t_a_r [NTRANS];
  logic signed [CW-1:0]  adj_r [NLANE];
  logic signed [W-1:0]   r0_b_r [NTRANS];
  logic signed [W-1:0]   t_b_r [NTRANS];
  logic                  vld_a_r, vld_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_a_r <= ctl_i.vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int k = 0; k < NLANE; k++) begin
        pa_r[k]  <= m_i[COF_IDX[k][0]] * m_i[COF_IDX[k][1]];
        pb_r[k]  <= m_i[COF_IDX[k][2]] * m_i[COF_IDX[k][3]];
        adj_r[k] <= CW'(pa_r[k]) - CW'(pb_r[k]);
      end
      for (int j = 0; j < NTRANS; j++) begin
        r0_a_r[j] <= m_i[j];
        t_a_r[j]  <= t_i[j];
        r0_b_r[j] <= r0_a_r[j];
        t_b_r[j]  <= t_a_r[j];
      end
    end
  end

  assign vld_o = vld_b_r;
  assign r0_o  = r0_b_r;
  assign t_o   = t_b_r;
  assign adj_o = adj_r;

endmodule

>>> design/aff_det.sv
// Determinant stages: split partial products, sum, then magnitudes,
// quotient signs and the degenerate test. Depends on aff_pkg.
module aff_det import aff_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  aff_ctl_t               ctl_i,
  input  logic signed [W-1:0]    r0_i [NTRANS],
  input  logic signed [W-1:0]    t_i [NTRANS],
  input  logic signed [2*W:0]    adj_i [NLANE],
  output logic                   vld_o,
  output logic [2*W+2*F:0]       num_o [NLANE],
  output logic                   neg_o [NLANE],
  output logic [3*W+1:0]         den_o,
  output logic                   degen_o,
  output logic signed [W-1:0]    t_o [NTRANS]
);
  localparam int CW = 2*W + 1;
  localparam int DW = 3*W + 2;
  localparam int NW = CW + 2*F;
  localparam logic [127:0] P3    = 128'd1 << (3*F);
  localparam logic [127:0] TEN12 = 128'd1000000000000;
  // |det| * 1e12 < 2^(3F)  <=>  |det| < ceil(2^(3F) / 1e12)
  localparam logic [DW-1:0] DEG_LIM = DW'((P3 + TEN12 - 128'd1) / TEN12);

  logic signed [CW-1:0] pl_nxt [NTRANS];
  logic signed [CW-1:0] ph_nxt [NTRANS];
  logic signed [CW-1:0] pl_r [NTRANS];
  logic signed [CW-1:0] ph_r [NTRANS];
  logic signed [CW-1:0] adj_c_r [NLANE];
  logic signed [W-1:0]  t_c_r [NTRANS];
  logic signed [DW-1:0] det_nxt;
  logic signed [DW-1:0] det_r;
  logic signed [CW-1:0] adj_d_r [NLANE];
  logic signed [W-1:0]  t_d_r [NTRANS];
  logic [DW-1:0]        absdet;
  logic [NW-1:0]        num_r [NLANE];
  logic                 neg_r [NLANE];
  logic [DW-1:0]        den_r;
  logic                 degen_r;
  logic signed [W-1:0]  t_e_r [NTRANS];
  logic                 vld_c_r, vld_d_r, vld_e_r;

  // split each cofactor into a signed high word and an unsigned low word
  always_comb begin
    for (int j = 0; j < NTRANS; j++) begin
      pl_nxt[j] = $signed(r0_i[j]) * $signed({1'b0, adj_i[DET_ADJ[j]][W-1:0]});
      ph_nxt[j] = $signed(r0_i[j]) * $signed(adj_i[DET_ADJ[j]][CW-1:W]);
    end
  end

  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < NTRANS; j++) begin
      det_nxt = det_nxt + (DW'(ph_r[j]) <<< W) + DW'(pl_r[j]);
    end
  end

  assign absdet = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_c_r <= ctl_i.vld;
      vld_d_r <= vld_c_r;
      vld_e_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      pl_r    <= pl_nxt;
      ph_r    <= ph_nxt;
      adj_c_r <= adj_i;
      t_c_r   <= t_i;
      det_r   <= det_nxt;
      adj_d_r <= adj_c_r;
      t_d_r   <= t_c_r;
      for (int k = 0; k < NLANE; k++) begin
        num_r[k] <= NW'(adj_d_r[k][CW-1] ? CW'(-adj_d_r[k]) : CW'(adj_d_r[k])) << (2*F);
        neg_r[k] <= adj_d_r[k][CW-1] ^ det_r[DW-1];
      end
      den_r   <= absdet;
      degen_r <= (absdet < DEG_LIM);
      t_e_r   <= t_d_r;
    end
  end

  assign vld_o   = vld_e_r;
  assign num_o   = num_r;
  assign neg_o   = neg_r;
  assign den_o   = den_r;
  assign degen_o = degen_r;
  assign t_o     = t_e_r;

endmodule

>>> design/aff_div.sv
// Pipelined restoring divider, nine lanes over one shared divisor.
// One quotient bit per stage plus an overflow stage. Depends on aff_pkg.
module aff_div import aff_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  aff_ctl_t            ctl_i,
  input  logic [2*W+2*F:0]    num_i [NLANE],
  input  logic                neg_i [NLANE],
  input  logic [3*W+1:0]      den_i,
  input  logic                degen_i,
  input  logic signed [W-1:0] t_i [NTRANS],
  output logic                vld_o,
  output logic [W:0]          mag_o [NLANE],
  output logic                ovf_o [NLANE],
  output logic                neg_o [NLANE],
  output logic                degen_o,
  output logic signed [W-1:0] t_o [NTRANS]
);
  localparam int DW = 3*W + 2;
  localparam int NW = 2*W + 1 + 2*F;
  localparam int QW = W + 1;
  localparam int NS = W + 2;
  localparam int XA = DW + QW + 1;
  localparam int XW = (XA > NW) ? XA : NW;

  logic [NW-1:0]       rem_nxt [NS][NLANE];
  logic [QW-1:0]       q_nxt [NS][NLANE];
  logic                ovf_nxt [NS][NLANE];
  logic [NW-1:0]       rem_r [NS][NLANE];
  logic [QW-1:0]       q_r [NS][NLANE];
  logic                ovf_r [NS][NLANE];
  logic                neg_r [NS][NLANE];
  logic [DW-1:0]       den_r [NS];
  logic                degen_r [NS];
  logic signed [W-1:0] t_r [NS][NTRANS];
  logic                vld_r [NS];

  always_comb begin
    logic [XW-1:0] sh;
    logic          ge;
    sh = '0;
    ge = 1'b0;
    // quotient beyond QW bits saturates anyway: flag it up front
    for (int l = 0; l < NLANE; l++) begin
      rem_nxt[0][l] = num_i[l];
      q_nxt[0][l]   = '0;
      ovf_nxt[0][l] = (XW'(num_i[l]) >= (XW'(den_i) << QW));
    end
    for (int s = 1; s < NS; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        sh = XW'(den_r[s-1]) << (QW - s);
        ge = (XW'(rem_r[s-1][l]) >= sh);
        rem_nxt[s][l] = ge ? NW'(XW'(rem_r[s-1][l]) - sh) : rem_r[s-1][l];
        q_nxt[s][l]   = q_r[s-1][l] | (ge ? (QW'(1) << (QW - s)) : QW'(0));
        ovf_nxt[s][l] = ovf_r[s-1][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) vld_r[s] <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r[0] <= ctl_i.vld;
      for (int s = 1; s < NS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
      ovf_r   <= ovf_nxt;
      neg_r[0]   <= neg_i;
      den_r[0]   <= den_i;
      degen_r[0] <= degen_i;
      t_r[0]     <= t_i;
      for (int s = 1; s < NS; s++) begin
        neg_r[s]   <= neg_r[s-1];
        den_r[s]   <= den_r[s-1];
        degen_r[s] <= degen_r[s-1];
        t_r[s]     <= t_r[s-1];
      end
    end
  end

  assign vld_o   = vld_r[NS-1];
  assign mag_o   = q_r[NS-1];
  assign ovf_o   = ovf_r[NS-1];
  assign neg_o   = neg_r[NS-1];
  assign degen_o = degen_r[NS-1];
  assign t_o     = t_r[NS-1];

endmodule

>>> design/aff_xlate.sv
// Output stages: saturate quotients, form -(R*t), truncate and saturate.
// Holds the output register. Depends on aff_pkg and assert_macros.svh.
`include "assert_macros.svh"
module aff_xlate import aff_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  aff_ctl_t            ctl_i,
  input  logic [W:0]          mag_i [NLANE],
  input  logic                ovf_i [NLANE],
  input  logic                neg_i [NLANE],
  input  logic                degen_i,
  input  logic signed [W-1:0] t_i [NTRANS],
  output logic                vld_o,
  output logic signed [W-1:0] m_o [NLANE],
  output logic signed [W-1:0] t_o [NTRANS]
);
  localparam int SXW = 2*W + 3;
  localparam logic signed [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0] QMAX = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0] QMIN = {2'b01, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] UNIT = (F <= W - 2) ? (W'(1) << F) : MAXP;
  localparam logic signed [SXW-1:0] HI_X = SXW'(MAXP);
  localparam logic signed [SXW-1:0] LO_X = SXW'(MINN);
  localparam logic signed [SXW-1:0] RND  = SXW'((64'd1 << F) - 64'd1);

  function automatic logic signed [W-1:0] sat_q(logic [W:0] mag, logic ovf, logic ng);
    logic [W:0] nm;
    nm = -mag;
    if (ng) begin
      sat_q = (ovf || mag > QMIN) ? MINN : $signed(nm[W-1:0]);
    end else begin
      sat_q = (ovf || mag > QMAX) ? MAXP : $signed(mag[W-1:0]);
    end
  endfunction

  logic signed [W-1:0]   res_e_r [NLANE];
  logic signed [W-1:0]   t_e_r [NTRANS];
  logic                  degen_e_r;
  logic signed [2*W-1:0] prod_f_r [NLANE];
  logic signed [W-1:0]   res_f_r [NLANE];
  logic                  degen_f_r;
  logic signed [SXW-1:0] x_nxt [NTRANS];
  logic signed [SXW-1:0] y_nxt [NTRANS];
  logic signed [W-1:0]   tr_nxt [NTRANS];
  logic signed [W-1:0]   m_g_r [NLANE];
  logic signed [W-1:0]   t_g_r [NTRANS];
  logic                  degen_g_r;
  logic                  vld_e_r, vld_f_r, vld_g_r;

  always_comb begin
    for (int r = 0; r < NTRANS; r++) begin
      x_nxt[r] = -(SXW'(prod_f_r[3*r]) + SXW'(prod_f_r[3*r+1]) + SXW'(prod_f_r[3*r+2]));
      // truncate toward zero
      y_nxt[r] = x_nxt[r][SXW-1] ? ((x_nxt[r] + RND) >>> F) : (x_nxt[r] >>> F);
      if (degen_f_r) begin
        tr_nxt[r] = '0;
      end else if (y_nxt[r] > HI_X) begin
        tr_nxt[r] = MAXP;
      end else if (y_nxt[r] < LO_X) begin
        tr_nxt[r] = MINN;
      end else begin
        tr_nxt[r] = y_nxt[r][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
      vld_g_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_e_r <= ctl_i.vld;
      vld_f_r <= vld_e_r;
      vld_g_r <= vld_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      for (int k = 0; k < NLANE; k++) begin
        if (degen_i) begin
          res_e_r[k] <= (k % 4 == 0) ? UNIT : '0;
        end else begin
          res_e_r[k] <= sat_q(mag_i[k], ovf_i[k], neg_i[k]);
        end
        prod_f_r[k] <= res_e_r[k] * t_e_r[k % 3];
      end
      t_e_r     <= t_i;
      degen_e_r <= degen_i;
      res_f_r   <= res_e_r;
      degen_f_r <= degen_e_r;
      m_g_r     <= res_f_r;
      t_g_r     <= tr_nxt;
      degen_g_r <= degen_f_r;
    end
  end

  assign vld_o = vld_g_r;
  assign m_o   = m_g_r;
  assign t_o   = t_g_r;

  `AFF_ASSERT_NXT(a_ovf_sat, ctl_i.en && ctl_i.vld && !degen_i && ovf_i[0] && !neg_i[0], res_e_r[0] == MAXP, "overflowed quotient not saturated")
  `AFF_ASSERT_IMP(a_degen_t, vld_g_r && degen_g_r, t_g_r[0] == '0 && t_g_r[1] == '0 && t_g_r[2] == '0, "degenerate result has nonzero translation")

endmodule
